[rtl/dbdf_pkg.sv]
// Package: shared types, widths, register codes and helpers of the detection box decoder.
`timescale 1ns / 1ps
`default_nettype none
package dbdf_pkg;

  localparam int unsigned CLASS_MAX       = 6;
  localparam int unsigned CLASS_COUNT_DEF = 6;
  localparam int unsigned CLASS_W         = 3;
  localparam int unsigned SCORE_W         = 16;
  localparam int unsigned COORD_W         = 16;
  localparam int unsigned SIZE_W          = 15;
  localparam int unsigned FRAME_W         = 12;
  localparam int unsigned EDGE_W          = 18;  // signed edge, 1/32 pixel, before clamp
  localparam int unsigned CEDGE_W         = 17;  // clamped edge, 1/32 pixel
  localparam int unsigned CFG_IDX_W       = 4;
  localparam int unsigned CFG_DATA_W      = 16;
  localparam int unsigned IN_DATA_W       = 160;
  localparam int unsigned OUT_DATA_W      = 80;

  localparam logic [FRAME_W-1:0] FRAME_RST     = 12'd640;
  localparam logic [SCORE_W-1:0] THRESHOLD_RST = 16'd16384;
  localparam logic [CEDGE_W-1:0] MIN_SPAN      = 17'd32;  // one whole pixel

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 4'd0,
    REG_FRAME_HEIGHT = 4'd1,
    REG_THRESHOLD0   = 4'd2,
    REG_THRESHOLD5   = 4'd7
  } reg_idx_e;

  // Input item as packed on the slave tdata, last declared field in the low bits.
  typedef struct packed {
    logic [1:0]                        pad;
    logic [CLASS_MAX-1:0][SCORE_W-1:0] score;
    logic [SIZE_W-1:0]                 box_height_in;
    logic [SIZE_W-1:0]                 box_width_in;
    logic signed [COORD_W-1:0]         centre_y;
    logic signed [COORD_W-1:0]         centre_x;
  } in_data_t;

  // Result item as packed on the master tdata.
  typedef struct packed {
    logic [SCORE_W-1:0] confidence;
    logic [COORD_W-1:0] height_out;
    logic [COORD_W-1:0] width_out;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] left;
  } out_data_t;

  typedef struct packed {
    logic               vld;
    logic [SCORE_W-1:0] score;
    logic [CLASS_W-1:0] cls;
  } cand_t;

  typedef struct packed {
    cand_t [2:0]               pair;
    logic signed [EDGE_W-1:0] l2;
    logic signed [EDGE_W-1:0] r2;
    logic signed [EDGE_W-1:0] t2;
    logic signed [EDGE_W-1:0] b2;
  } stage1_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [CLASS_W-1:0] cls;
    logic [CEDGE_W-1:0] l2;
    logic [CEDGE_W-1:0] r2;
    logic [CEDGE_W-1:0] t2;
    logic [CEDGE_W-1:0] b2;
  } stage2_t;

  // Lower-index candidate a wins ties; a valid b takes over on a strictly higher score or when a is not valid.
  function automatic cand_t pick(cand_t a, cand_t b);
    cand_t r;
    r = a;
    if (b.vld && (!a.vld || (b.score > a.score))) begin
      r = b;
    end
    return r;
  endfunction

  function automatic logic [CEDGE_W-1:0] clamp_edge(logic signed [EDGE_W-1:0] v,
                                                    logic [CEDGE_W-1:0] hi);
    logic [CEDGE_W-1:0] r;
    r = v[CEDGE_W-1:0];
    if (v[EDGE_W-1]) begin
      r = '0;
    end else if (v[CEDGE_W-1:0] > hi) begin
      r = hi;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/detection_box_decode_filter_top.sv]
// Top level: detection box decode, score threshold, frame clamp and size filter.
`timescale 1ns / 1ps
`default_nettype none
// Takes one candidate box per cycle while s_axis_tready is high and returns zero or
// one box per input through three register stages. Stage one forms the
// pairwise class winners and the unclamped corner edges, stage two finishes the
// class choice and clamps the edges to the frame, stage three applies the class
// threshold and the one-pixel size check and holds the result in the output
// register. A stage takes a new item when empty or when the next can move, so a
// held output stalls only when every stage is full. Dropped boxes leave no item.
// Configuration writes are taken at once (cfg_ready_o is always high) and must be
// made while no box is in flight.
module detection_box_decode_filter_top #(
  parameter int unsigned CLASS_COUNT = dbdf_pkg::CLASS_COUNT_DEF
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // slave tdata, low to high: centre_x, centre_y, box_width_in, box_height_in,
  // score0..score5, two zero pad bits
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire  [dbdf_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // master tdata, low to high: left, top, width_out, height_out, confidence
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  output logic [dbdf_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // master tuser: class_id
  output logic [dbdf_pkg::CLASS_W-1:0]       m_axis_tuser,
  input  wire                                cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire  [dbdf_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire  [dbdf_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  // Configuration registers
  logic [dbdf_pkg::FRAME_W-1:0]                   frame_w_q, frame_h_q;
  logic [dbdf_pkg::CLASS_MAX-1:0][dbdf_pkg::SCORE_W-1:0] thr_q;
  logic [dbdf_pkg::CFG_IDX_W-1:0]                 thr_off;
  logic [dbdf_pkg::CLASS_W-1:0]                   thr_idx;

  assign cfg_ready_o = 1'b1;
  assign thr_off     = cfg_index_i - dbdf_pkg::REG_THRESHOLD0;
  assign thr_idx     = thr_off[dbdf_pkg::CLASS_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_w_q <= dbdf_pkg::FRAME_RST;
      frame_h_q <= dbdf_pkg::FRAME_RST;
      for (int i = 0; i < dbdf_pkg::CLASS_MAX; i++) begin
        thr_q[i] <= dbdf_pkg::THRESHOLD_RST;
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i) inside
        dbdf_pkg::REG_FRAME_WIDTH: begin
          frame_w_q <= cfg_data_i[dbdf_pkg::FRAME_W-1:0];
        end
        dbdf_pkg::REG_FRAME_HEIGHT: begin
          frame_h_q <= cfg_data_i[dbdf_pkg::FRAME_W-1:0];
        end
        [dbdf_pkg::REG_THRESHOLD0:dbdf_pkg::REG_THRESHOLD5]: begin
          thr_q[thr_idx] <= cfg_data_i;
        end
        default: begin
          // unknown index: drop the write
        end
      endcase
    end
  end

  // Pipeline handshake
  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  assign rdy3          = !v3_q || m_axis_tready;
  assign rdy2          = !v2_q || rdy3;
  assign rdy1          = !v1_q || rdy2;
  assign s_axis_tready = rdy1;

  // Stage 1: pairwise class winners and unclamped edges
  dbdf_pkg::in_data_t                       in_d;
  dbdf_pkg::cand_t [dbdf_pkg::CLASS_MAX-1:0] cand;
  dbdf_pkg::stage1_t                        s1_d, s1_q;
  logic signed [dbdf_pkg::EDGE_W-1:0]       cx2, cy2, bw, bh;

  assign in_d = dbdf_pkg::in_data_t'(s_axis_tdata);

  always_comb begin
    for (int i = 0; i < dbdf_pkg::CLASS_MAX; i++) begin
      cand[i].vld   = (i < CLASS_COUNT);
      cand[i].score = in_d.score[i];
      cand[i].cls   = dbdf_pkg::CLASS_W'(i);
    end
    for (int p = 0; p < 3; p++) begin
      s1_d.pair[p] = dbdf_pkg::pick(cand[2*p], cand[2*p+1]);
    end
    cx2     = $signed({in_d.centre_x[dbdf_pkg::COORD_W-1], in_d.centre_x, 1'b0});
    cy2     = $signed({in_d.centre_y[dbdf_pkg::COORD_W-1], in_d.centre_y, 1'b0});
    bw      = $signed({3'b000, in_d.box_width_in});
    bh      = $signed({3'b000, in_d.box_height_in});
    s1_d.l2 = cx2 - bw;
    s1_d.r2 = cx2 + bw;
    s1_d.t2 = cy2 - bh;
    s1_d.b2 = cy2 + bh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && s_axis_tvalid) begin
      s1_q <= s1_d;
    end
  end

  // Stage 2: final class choice and frame clamp
  dbdf_pkg::stage2_t            s2_d, s2_q;
  dbdf_pkg::cand_t              best;
  logic [dbdf_pkg::CEDGE_W-1:0] xmax, ymax;

  always_comb begin
    // groups stay in index order so ties keep the lowest class
    best       = dbdf_pkg::pick(dbdf_pkg::pick(s1_q.pair[0], s1_q.pair[1]), s1_q.pair[2]);
    xmax       = {frame_w_q, 5'b00000};
    ymax       = {frame_h_q, 5'b00000};
    s2_d.score = best.score;
    s2_d.cls   = best.cls;
    s2_d.l2    = dbdf_pkg::clamp_edge(s1_q.l2, xmax);
    s2_d.r2    = dbdf_pkg::clamp_edge(s1_q.r2, xmax);
    s2_d.t2    = dbdf_pkg::clamp_edge(s1_q.t2, ymax);
    s2_d.b2    = dbdf_pkg::clamp_edge(s1_q.b2, ymax);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      s2_q <= s2_d;
    end
  end

  // Stage 3: threshold and size filter into the output register
  logic [dbdf_pkg::CEDGE_W-1:0] w2, h2;
  logic                         keep;
  dbdf_pkg::out_data_t          out_d, out_q;
  logic [dbdf_pkg::CLASS_W-1:0] cls_q;

  always_comb begin
    w2               = s2_q.r2 - s2_q.l2;
    h2               = s2_q.b2 - s2_q.t2;
    keep             = (s2_q.score >= thr_q[s2_q.cls]) &&
                       (w2 >= dbdf_pkg::MIN_SPAN) && (h2 >= dbdf_pkg::MIN_SPAN);
    out_d.left       = s2_q.l2[dbdf_pkg::CEDGE_W-1:1];
    out_d.top        = s2_q.t2[dbdf_pkg::CEDGE_W-1:1];
    out_d.width_out  = w2[dbdf_pkg::CEDGE_W-1:1];
    out_d.height_out = h2[dbdf_pkg::CEDGE_W-1:1];
    out_d.confidence = s2_q.score;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (rdy3) begin
      v3_q <= v2_q && keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      out_q <= out_d;
      cls_q <= s2_q.cls;
    end
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = out_q;
  assign m_axis_tuser  = cls_q;

`ifndef SYNTHESIS
  // back-pressure at the input only when every stage is full behind a held output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled while the pipeline has room");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_q.width_out >= 16'd16 && out_q.height_out >= 16'd16))
    else $error("box narrower than one pixel emitted");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser < CLASS_COUNT))
    else $error("class index out of range");
`endif

endmodule
`default_nettype wire
